[sv/atdr_pkg.sv]
// ---------------------------------------------------------------------------
// atdr_pkg
// Shared widths, constants, beat type and angle table for the CORDIC
// arctangent unit.
// ---------------------------------------------------------------------------
package atdr_pkg;

  // Number format and CORDIC depth
  localparam int ITERATIONS = 20;
  localparam int FRAC_BITS  = 16;
  localparam int GUARD_BITS = 28;

  // Datapath widths
  localparam int IN_W   = 32;
  localparam int OUT_W  = 24;
  localparam int XW     = 64;
  localparam int ZW     = 34;
  localparam int STEP_W = 5;
  localparam int DEGW   = 31;
  localparam int PW     = ZW + DEGW;

  // Rounding shifts for the two units
  localparam int DEG_SH = 54 - FRAC_BITS;
  localparam int RAD_SH = 30 - FRAC_BITS;

  // 180/pi in Q8.24
  localparam logic signed [DEGW-1:0] DEG_PER_RAD = DEGW'(961263669);

  // Start value of x: one in the guarded format
  localparam logic signed [XW-1:0] X_INIT = XW'(1) <<< (FRAC_BITS + GUARD_BITS);

  // Result range
  localparam logic signed [PW-1:0] SAT_HI = PW'(8388607);
  localparam logic signed [PW-1:0] SAT_LO = -PW'(8388608);

  // Result unit codes
  localparam logic UNIT_RAD = 1'b0;
  localparam logic UNIT_DEG = 1'b1;

  // atan(2^-i) in Q2.30 for the steps with no power-of-two form
  localparam logic [29:0] ATAN_LOW [10] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149
  };

  // One beat travelling down the cell row
  typedef struct packed {
    logic                 vld;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } atdr_beat_t;

  // Angle step for CORDIC step i, Q2.30
  function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
    logic signed [ZW-1:0] res;
    if (i < STEP_W'(10)) begin
      res = ZW'(ATAN_LOW[i[3:0]]);
    end else if (i <= STEP_W'(30)) begin
      res = ZW'(64'd1 << (STEP_W'(30) - i));
    end else begin
      res = '0;
    end
    return res;
  endfunction

endpackage

[sv/atdr_in_if.sv]
// ---------------------------------------------------------------------------
// atdr_in_if
// Input channel: one tangent value per beat.
// ---------------------------------------------------------------------------
interface atdr_in_if
  import atdr_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] tangent_value;

  modport source (output valid, output tangent_value, input ready);
  modport sink   (input valid, input tangent_value, output ready);
endinterface

[sv/atdr_out_if.sv]
// ---------------------------------------------------------------------------
// atdr_out_if
// Result channel: one angle per beat.
// ---------------------------------------------------------------------------
interface atdr_out_if
  import atdr_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

[sv/atdr_cfg_if.sv]
// ---------------------------------------------------------------------------
// atdr_cfg_if
// Configuration write channel for the angle unit register.
// ---------------------------------------------------------------------------
interface atdr_cfg_if
  import atdr_pkg::*;
  ();
  logic valid;
  logic ready;
  logic angle_unit;

  modport source (output valid, output angle_unit, input ready);
  modport sink   (input valid, input angle_unit, output ready);
endinterface

[sv/atdr_cell.sv]
// ---------------------------------------------------------------------------
// atdr_cell
// One CORDIC vectoring step with its own stage register and handshake.
// ---------------------------------------------------------------------------
module atdr_cell
  import atdr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [STEP_W-1:0] step_idx,
  input  atdr_beat_t        up,
  output logic              up_rdy,
  output atdr_beat_t        dn,
  input  logic              dn_rdy
);

  atdr_beat_t           dn_r;
  logic signed [XW-1:0] x_nxt;
  logic signed [XW-1:0] y_nxt;
  logic signed [ZW-1:0] z_nxt;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] ang;
  logic                 y_pos;

  // Take a beat when the stage is empty or its beat moves on
  assign up_rdy = !dn_r.vld || dn_rdy;

  // Rotate towards y = 0
  always_comb begin
    xs    = up.x >>> step_idx;
    ys    = up.y >>> step_idx;
    ang   = atan_entry(step_idx);
    y_pos = !up.y[XW-1] && (up.y != '0);
    if (y_pos) begin
      x_nxt = up.x + ys;
      y_nxt = up.y - xs;
      z_nxt = up.z + ang;
    end else begin
      x_nxt = up.x - ys;
      y_nxt = up.y + xs;
      z_nxt = up.z - ang;
    end
  end

  // Stage register: clear valid in reset, load payload with each taken beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_r.vld <= 1'b0;
    end else if (up_rdy) begin
      dn_r.vld <= up.vld;
      if (up.vld) begin
        dn_r.x <= x_nxt;
        dn_r.y <= y_nxt;
        dn_r.z <= z_nxt;
      end
    end
  end

  assign dn = dn_r;

`ifndef SYNTH
  // An accepted beat lands in the stage
  a_take_lands : assert property (@(posedge clk) disable iff (!rst_n)
    up.vld && up_rdy |=> dn_r.vld)
    else $error("atdr_cell: accepted beat lost");

  // x starts at one and only grows, so it never turns negative
  a_x_positive : assert property (@(posedge clk) disable iff (!rst_n)
    dn_r.vld |-> !dn_r.x[XW-1])
    else $error("atdr_cell: x went negative");

  // A stalled stage keeps its beat
  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    dn_r.vld && !dn_rdy |=> dn_r.vld && $stable(dn_r.z))
    else $error("atdr_cell: stalled beat changed");
`endif

endmodule

[sv/atdr_scale.sv]
// ---------------------------------------------------------------------------
// atdr_scale
// Unit conversion of the Q2.30 radian angle: multiply by 180/pi or pass,
// then round, saturate and hold in the output register.
// ---------------------------------------------------------------------------
module atdr_scale
  import atdr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    unit_deg,
  input  atdr_beat_t              up,
  output logic                    up_rdy,
  output logic                    out_vld,
  input  logic                    out_rdy,
  output logic signed [OUT_W-1:0] angle
);

  localparam logic signed [PW-1:0] DEG_HALF = PW'(1) <<< (DEG_SH - 1);
  localparam logic signed [ZW-1:0] RAD_HALF = ZW'(1) <<< (RAD_SH - 1);

  logic                    vld_a_r;
  logic                    deg_a_r;
  logic signed [PW-1:0]    prod_a_r;
  logic signed [ZW-1:0]    z_a_r;
  logic signed [PW-1:0]    prod_nxt;
  logic                    rdy_a;
  logic                    rdy_b;
  logic signed [PW-1:0]    deg_sum;
  logic signed [ZW-1:0]    rad_sum;
  logic signed [PW-1:0]    res;
  logic signed [OUT_W-1:0] angle_nxt;
  logic                    out_vld_r;
  logic signed [OUT_W-1:0] angle_r;

  assign rdy_b  = !out_vld_r || out_rdy;
  assign rdy_a  = !vld_a_r || rdy_b;
  assign up_rdy = rdy_a;

  // Multiply by 180/pi
  assign prod_nxt = up.z * DEG_PER_RAD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (rdy_a) begin
      vld_a_r <= up.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && up.vld) begin
      prod_a_r <= prod_nxt;
      z_a_r    <= up.z;
      deg_a_r  <= unit_deg;
    end
  end

  // Round half up, then clamp to the result range
  always_comb begin
    deg_sum = prod_a_r + DEG_HALF;
    rad_sum = z_a_r + RAD_HALF;
    if (deg_a_r == UNIT_DEG) begin
      res = deg_sum >>> DEG_SH;
    end else begin
      res = PW'(rad_sum >>> RAD_SH);
    end
    if (res > SAT_HI) begin
      angle_nxt = SAT_HI[OUT_W-1:0];
    end else if (res < SAT_LO) begin
      angle_nxt = SAT_LO[OUT_W-1:0];
    end else begin
      angle_nxt = res[OUT_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (rdy_b) begin
      out_vld_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && vld_a_r) begin
      angle_r <= angle_nxt;
    end
  end

  assign out_vld = out_vld_r;
  assign angle   = angle_r;

`ifndef SYNTH
  // With sixteen fraction bits the angle never leaves +/-90 degrees
  a_angle_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (angle_r <= OUT_W'(5898240)) && (angle_r >= -OUT_W'(5898240)))
    else $error("atdr_scale: angle out of range");

  // A multiplied beat moves into a free output register
  a_a_to_out : assert property (@(posedge clk) disable iff (!rst_n)
    vld_a_r && rdy_b |=> out_vld_r)
    else $error("atdr_scale: beat lost before output");

  // A waiting result holds
  a_out_holds : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_rdy |=> out_vld_r && $stable(angle_r))
    else $error("atdr_scale: waiting result changed");
`endif

endmodule

[sv/arctangent_deg_rad_unit.sv]
// ---------------------------------------------------------------------------
// arctangent_deg_rad_unit
// Principal arctangent of a signed Q16.16 number, in degrees or radians.
// ---------------------------------------------------------------------------
// The unit takes one Q16.16 tangent per beat and returns atan of it as a
// 24-bit signed Q8.16 angle, in degrees (reset choice) or radians as set by
// the one-bit angle_unit register (1 degrees, 0 radians). A row of 20 CORDIC
// cells in vectoring mode, started at x = 1 and y = input, is followed by a
// multiply stage and a round/saturate output register, all registered, so
// a new beat is taken every cycle unless a result-side stall has backed
// the row up. A stall on the result side fills bubbles in the row first,
// so input keeps flowing until the row is full. Write angle_unit only
// while no beat is in flight.
// ---------------------------------------------------------------------------
module arctangent_deg_rad_unit
  import atdr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  atdr_in_if.sink    in_ch,
  atdr_out_if.source out_ch,
  atdr_cfg_if.sink   cfg_ch
);

  atdr_beat_t stage [ITERATIONS+1];
  logic       rdy   [ITERATIONS+1];
  logic       unit_r;

  // Configuration register, always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r <= UNIT_DEG;
    end else if (cfg_ch.valid) begin
      unit_r <= cfg_ch.angle_unit;
    end
  end

  // Seed the row: x = one, y = input in the guarded format
  always_comb begin
    stage[0].vld = in_ch.valid;
    stage[0].x   = X_INIT;
    stage[0].y   = XW'(in_ch.tangent_value) <<< GUARD_BITS;
    stage[0].z   = '0;
  end

  assign in_ch.ready = rdy[0];

  // CORDIC cell row
  for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
    atdr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .step_idx (STEP_W'(k)),
      .up       (stage[k]),
      .up_rdy   (rdy[k]),
      .dn       (stage[k+1]),
      .dn_rdy   (rdy[k+1])
    );
  end

  // Unit conversion and output register
  atdr_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .unit_deg (unit_r),
    .up       (stage[ITERATIONS]),
    .up_rdy   (rdy[ITERATIONS]),
    .out_vld  (out_ch.valid),
    .out_rdy  (out_ch.ready),
    .angle    (out_ch.angle)
  );

`ifndef SYNTH
  // With the result side ready, every stage moves and input is taken
  a_ready_chain : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("arctangent_deg_rad_unit: ready chain broken");

  // A configuration beat lands in the unit register
  a_cfg_write : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ch.valid && cfg_ch.ready |=> unit_r == $past(cfg_ch.angle_unit))
    else $error("arctangent_deg_rad_unit: unit write lost");

  // An accepted beat enters the first cell
  a_in_enters : assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> stage[1].vld)
    else $error("arctangent_deg_rad_unit: input beat lost");
`endif

endmodule

[tb/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the CORDIC arctangent unit. Tangent beats go in,
// every accepted beat is scored against a bit-true CORDIC predictor, and
// each result beat is compared with the oldest predicted angle. Traffic
// runs in phases with both angle units, random gaps on either side and one
// long result-side hold-off that backs the cell row up into the input.
// ---------------------------------------------------------------------------
module testbench
  import atdr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Pipeline depth from input beat to result beat, and bench limits
  localparam int LATENCY     = 22;
  localparam int DRAIN       = 2 * LATENCY;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_OFF    = 300;
  localparam int PHASE_BEATS = 106;

  // 180/pi in Q8.24 and atan(2^-i) in Q2.30 for the first ten steps
  localparam longint DEG_Q24 = 961263669;
  localparam longint ATAN_Q30 [10] = '{
    843314856, 497837829, 263043836, 133525158, 67021686,
    33543515,  16775850,  8388437,   4194282,   2097149
  };

  // Directed tangents: zero, one LSB either side, range ends, +-1.0,
  // tan 60 and -tan 30, alternating bit patterns and one half
  localparam logic signed [IN_W-1:0] DIRECTED [12] = '{
    32'sh0000_0000, 32'sh0000_0001, -32'sh0000_0001, 32'sh7FFF_FFFF,
    32'sh8000_0000, 32'sh0001_0000, -32'sh0001_0000, 32'sh0001_BB68,
    -32'sh0000_93CD, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_8000
  };

  typedef enum {
    TRAFFIC_FREE,
    TRAFFIC_SENDER_IDLE,
    TRAFFIC_RECEIVER_STALL,
    TRAFFIC_BOTH
  } traffic_t;

  logic clk;
  logic rst_n;

  atdr_in_if  in_if ();
  atdr_out_if out_if ();
  atdr_cfg_if cfg_if ();

  arctangent_deg_rad_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Bench copy of the unit register and the predicted angles in flight
  logic                    unit_now = UNIT_DEG;
  logic signed [OUT_W-1:0] angle_q [$];
  int                      errors       = 0;
  int                      quiet_cycles = 0;
  int                      src_idle_pct = 0;
  int                      snk_idle_pct = 0;
  int                      hold_cycles  = 0;

  // Bit-true CORDIC arctangent in vectoring mode
  function automatic logic signed [OUT_W-1:0] cordic_angle(
    input logic signed [IN_W-1:0] tangent,
    input logic                   unit
  );
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    longint step;
    longint r;
    x = longint'(1) <<< (FRAC_BITS + GUARD_BITS);
    y = longint'(tangent) <<< GUARD_BITS;
    z = 0;
    for (int i = 0; i < ITERATIONS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (i < 10) begin
        step = ATAN_Q30[i];
      end else if (i <= 30) begin
        step = longint'(1) <<< (30 - i);
      end else begin
        step = 0;
      end
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + step;
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - step;
      end
    end
    if (unit == UNIT_DEG) begin
      r = (z * DEG_Q24 + (longint'(1) <<< (53 - FRAC_BITS))) >>> (54 - FRAC_BITS);
    end else begin
      r = (z + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    end
    if (r > 8388607) begin
      r = 8388607;
    end
    if (r < -8388608) begin
      r = -8388608;
    end
    return r[OUT_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t mismatch: %s (expected %0d, got %0d)", $realtime, what, want, got);
    errors++;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Known values on every input from time zero
  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.tangent_value = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.angle_unit  = UNIT_DEG;
    out_if.ready       = 1'b0;
  end

  // Result side: long hold-off first, otherwise random stalls
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Track register writes and predict every accepted tangent beat
  always @(posedge clk) begin
    if (rst_n && cfg_if.valid && cfg_if.ready) begin
      unit_now <= cfg_if.angle_unit;
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      angle_q.push_back(cordic_angle(in_if.tangent_value, unit_now));
    end
  end

  // Score result beats against the oldest prediction
  always @(posedge clk) begin
    logic signed [OUT_W-1:0] want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (angle_q.size() == 0) begin
        report_mismatch("result beat with nothing outstanding", 0, out_if.angle);
      end else begin
        want = angle_q.pop_front();
        if (out_if.angle !== want) begin
          report_mismatch("angle", want, out_if.angle);
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves on any channel for too long
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one tangent beat after any sender gap, hold until accepted
  task automatic send_tangent(input logic signed [IN_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.tangent_value <= value;
    @(posedge clk);
    while (!in_if.ready) begin
      @(posedge clk);
    end
  endtask

  // Drop valid after the last beat of a burst
  task automatic close_burst();
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  // Wait for every predicted angle, then let the row empty out
  task automatic drain();
    while (angle_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_unit(input logic unit);
    @(negedge clk);
    cfg_if.valid      <= 1'b1;
    cfg_if.angle_unit <= unit;
    @(posedge clk);
    while (!cfg_if.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_traffic(input traffic_t mode);
    case (mode)
      TRAFFIC_SENDER_IDLE: begin
        src_idle_pct = 85;
        snk_idle_pct = 0;
      end
      TRAFFIC_RECEIVER_STALL: begin
        src_idle_pct = 0;
        snk_idle_pct = 85;
      end
      TRAFFIC_BOTH: begin
        src_idle_pct = 30;
        snk_idle_pct = 30;
      end
      default: begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
    endcase
  endtask

  task automatic run_directed();
    foreach (DIRECTED[k]) begin
      send_tangent(DIRECTED[k]);
    end
    close_burst();
    drain();
  endtask

  // Random tangents: full range, small values, near zero, every magnitude, directed picks
  task automatic run_random(input traffic_t mode, input logic unit, input bit squeeze);
    logic signed [IN_W-1:0] value;
    write_unit(unit);
    set_traffic(mode);
    if (squeeze) begin
      @(posedge clk);
      hold_cycles = HOLD_OFF;
    end
    repeat (PHASE_BEATS) begin
      case ($urandom_range(0, 5))
        0, 1: value = $urandom;
        2: value = $urandom_range(0, 8 * 65536) - 4 * 65536;
        3: value = $urandom_range(0, 64) - 32;
        4: begin
          value = $urandom >> $urandom_range(0, 31);
          if ($urandom_range(0, 1) == 1) begin
            value = -value;
          end
        end
        default: value = DIRECTED[$urandom_range(0, 6)];
      endcase
      send_tangent(value);
    end
    close_burst();
    drain();
  endtask

  // Sequence the run
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows in the reset unit, then in radians
    set_traffic(TRAFFIC_FREE);
    run_directed();
    write_unit(UNIT_RAD);
    run_directed();

    // Random phases across both units and every traffic shape
    run_random(TRAFFIC_FREE,           UNIT_DEG, 1'b0);
    run_random(TRAFFIC_SENDER_IDLE,    UNIT_RAD, 1'b0);
    run_random(TRAFFIC_RECEIVER_STALL, UNIT_DEG, 1'b0);
    run_random(TRAFFIC_BOTH,           UNIT_RAD, 1'b0);
    run_random(TRAFFIC_FREE,           UNIT_DEG, 1'b1);

    if (angle_q.size() != 0) begin
      report_mismatch("angles still outstanding at end", 0, angle_q.size());
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[arctangent_deg_rad_unit.f]
sv/atdr_pkg.sv
sv/atdr_in_if.sv
sv/atdr_out_if.sv
sv/atdr_cfg_if.sv
sv/atdr_cell.sv
sv/atdr_scale.sv
sv/arctangent_deg_rad_unit.sv
tb/testbench.sv
